// ===== rtl/mrsp_pkg.sv =====
// Shared types and constants for the MIDI running status parser.
// Depends on nothing; every rtl file imports it.
package mrsp_pkg;

   // Default depth of the queue between the classifier and the parser
   localparam int QUEUE_DEPTH = 2;

   // Configuration register indexes
   localparam logic [1:0] CSR_CHANNEL_A = 2'd0;
   localparam logic [1:0] CSR_CHANNEL_B = 2'd1;
   localparam logic [1:0] CSR_CHANNEL_C = 2'd2;

   // Reset values of the listened channels
   localparam logic [3:0] CHANNEL_A_RESET = 4'd0;
   localparam logic [3:0] CHANNEL_B_RESET = 4'd1;
   localparam logic [3:0] CHANNEL_C_RESET = 4'd2;

   // Status byte high nibbles that start a message
   localparam logic [3:0] STATUS_NOTE_OFF = 4'h8;
   localparam logic [3:0] STATUS_NOTE_ON  = 4'h9;
   localparam logic [3:0] STATUS_CONTROL  = 4'hB;
   localparam logic [3:0] STATUS_PROGRAM  = 4'hC;
   localparam logic [3:0] STATUS_PITCH    = 4'hE;

   // Banks
   localparam logic [1:0] BANK_A = 2'd0;
   localparam logic [1:0] BANK_B = 2'd1;
   localparam logic [1:0] BANK_C = 2'd2;

   // What the classifier decided about one byte
   typedef enum logic [2:0] {
      CMD_DATA,
      CMD_IGNORE,
      CMD_NOTE_ON,
      CMD_NOTE_OFF,
      CMD_PROGRAM,
      CMD_CONTROL,
      CMD_PITCH
   } cmd_type;

   // Result message kinds
   typedef enum logic [2:0] {
      KIND_NOTE_ON  = 3'd0,
      KIND_NOTE_OFF = 3'd1,
      KIND_PROGRAM  = 3'd2,
      KIND_CONTROL  = 3'd3,
      KIND_PITCH    = 3'd4
   } kind_type;

   // Parser states
   typedef enum logic [3:0] {
      ST_IGNORE = 4'd0,
      ST_NON_1  = 4'd1,
      ST_NON_2  = 4'd2,
      ST_NOFF_1 = 4'd3,
      ST_NOFF_2 = 4'd4,
      ST_PC     = 4'd5,
      ST_CC_1   = 4'd6,
      ST_CC_2   = 4'd7,
      ST_PW_1   = 4'd8,
      ST_PW_2   = 4'd9
   } parse_state_type;

   // One classified item as it travels through the queue
   typedef struct packed {
      cmd_type    cmd;
      logic [1:0] bank;
      logic [6:0] data;
   } item_type;

endpackage

// ===== rtl/mrsp_front.sv =====
// Front end: channel registers and byte classification.
// Depends on mrsp_pkg.
module mrsp_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [7:0]          req_midi_byte,
   output logic                req_stall,
   input  logic                csr_write_en,
   input  logic [1:0]          csr_index,
   input  logic [3:0]          csr_wdata,
   input  logic                queue_full,
   output logic                push,
   output mrsp_pkg::item_type  push_item
);
   import mrsp_pkg::*;

   logic [3:0] channel_a_ff, channel_a_in;
   logic [3:0] channel_b_ff, channel_b_in;
   logic [3:0] channel_c_ff, channel_c_in;

   logic       is_a, is_b, is_c;
   logic [1:0] bank3, bank2;
   cmd_type    cmd;

   // Configuration writes
   always_comb begin
      channel_a_in = channel_a_ff;
      channel_b_in = channel_b_ff;
      channel_c_in = channel_c_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_CHANNEL_A: channel_a_in = csr_wdata;
            CSR_CHANNEL_B: channel_b_in = csr_wdata;
            CSR_CHANNEL_C: channel_c_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         channel_a_ff <= CHANNEL_A_RESET;
         channel_b_ff <= CHANNEL_B_RESET;
         channel_c_ff <= CHANNEL_C_RESET;
      end else begin
         channel_a_ff <= channel_a_in;
         channel_b_ff <= channel_b_in;
         channel_c_ff <= channel_c_in;
      end
   end

   // Channel match with A over B over C priority
   assign is_a  = (req_midi_byte[3:0] == channel_a_ff);
   assign is_b  = (req_midi_byte[3:0] == channel_b_ff);
   assign is_c  = (req_midi_byte[3:0] == channel_c_ff);
   assign bank3 = is_a ? BANK_A : (is_b ? BANK_B : BANK_C);
   // program change and pitch wheel only reach banks A and B
   assign bank2 = is_a ? BANK_A : BANK_B;

   // Classify the byte
   always_comb begin
      cmd = CMD_IGNORE;
      if (!req_midi_byte[7]) begin
         cmd = CMD_DATA;
      end else if (is_a || is_b || is_c) begin
         case (req_midi_byte[7:4])
            STATUS_NOTE_ON:  cmd = CMD_NOTE_ON;
            STATUS_NOTE_OFF: cmd = CMD_NOTE_OFF;
            STATUS_PROGRAM:  cmd = CMD_PROGRAM;
            STATUS_PITCH:    cmd = CMD_PITCH;
            STATUS_CONTROL:  cmd = CMD_CONTROL;
            default:         cmd = CMD_IGNORE;
         endcase
      end
   end

   assign push_item.cmd  = cmd;
   assign push_item.bank = (cmd == CMD_PROGRAM || cmd == CMD_PITCH) ? bank2 : bank3;
   assign push_item.data = req_midi_byte[6:0];

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

endmodule

// ===== rtl/mrsp_queue.sv =====
// Short queue of classified items between front end and parser.
// Depends on mrsp_pkg.
module mrsp_queue #(
   parameter int Depth = mrsp_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  mrsp_pkg::item_type  push_item,
   output logic                full,
   input  logic                pop,
   output logic                pop_valid,
   output mrsp_pkg::item_type  pop_item
);
   import mrsp_pkg::*;

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   item_type        slot_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   assign full      = (count_ff == CntW'(Depth));
   assign pop_valid = (count_ff != '0);
   assign pop_item  = slot_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("queue written while full");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> pop_valid)
      else $error("queue read while empty");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(Depth))
      else $error("queue count past depth");

endmodule

// ===== rtl/mrsp_back.sv =====
// Back end: running status parse state machine and result register.
// Depends on mrsp_pkg.
module mrsp_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                pop_valid,
   input  mrsp_pkg::item_type  pop_item,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [2:0]          rsp_message_kind,
   output logic [6:0]          rsp_first_data,
   output logic [6:0]          rsp_second_data,
   output logic [1:0]          rsp_bank
);
   import mrsp_pkg::*;

   parse_state_type state_ff, state_in;
   logic [6:0]      held_first_ff, held_first_in;
   logic [1:0]      held_bank_ff, held_bank_in;

   logic            rsp_valid_ff, rsp_valid_in;
   kind_type        kind_ff, kind_in;
   logic [6:0]      first_ff, first_in;
   logic [6:0]      second_ff, second_in;
   logic [1:0]      bank_ff;
   logic            emit;

   // Take an item when the result register is free or being drained
   assign pop = pop_valid && (!rsp_valid_ff || !rsp_stall);

   // Next state and result
   always_comb begin
      state_in      = state_ff;
      held_first_in = held_first_ff;
      held_bank_in  = held_bank_ff;
      emit          = 1'b0;
      kind_in       = KIND_NOTE_ON;
      first_in      = held_first_ff;
      second_in     = pop_item.data;
      if (pop) begin
         case (pop_item.cmd)
            CMD_IGNORE: state_in = ST_IGNORE;
            CMD_NOTE_ON: begin
               state_in     = ST_NON_1;
               held_bank_in = pop_item.bank;
            end
            CMD_NOTE_OFF: begin
               state_in     = ST_NOFF_1;
               held_bank_in = pop_item.bank;
            end
            CMD_PROGRAM: begin
               state_in     = ST_PC;
               held_bank_in = pop_item.bank;
            end
            CMD_CONTROL: begin
               state_in     = ST_CC_1;
               held_bank_in = pop_item.bank;
            end
            CMD_PITCH: begin
               state_in     = ST_PW_1;
               held_bank_in = pop_item.bank;
            end
            CMD_DATA: begin
               case (state_ff)
                  ST_IGNORE: ;
                  ST_NON_1: begin
                     held_first_in = pop_item.data;
                     state_in      = ST_NON_2;
                  end
                  ST_NON_2: begin
                     state_in = ST_NON_1;
                     emit     = 1'b1;
                     // zero velocity note on counts as note off
                     kind_in  = (pop_item.data == '0) ? KIND_NOTE_OFF : KIND_NOTE_ON;
                  end
                  ST_NOFF_1: begin
                     held_first_in = pop_item.data;
                     state_in      = ST_NOFF_2;
                  end
                  ST_NOFF_2: begin
                     state_in = ST_NOFF_1;
                     emit     = 1'b1;
                     kind_in  = KIND_NOTE_OFF;
                  end
                  ST_PC: begin
                     emit      = 1'b1;
                     kind_in   = KIND_PROGRAM;
                     first_in  = pop_item.data;
                     second_in = '0;
                  end
                  ST_CC_1: begin
                     held_first_in = pop_item.data;
                     state_in      = ST_CC_2;
                  end
                  ST_CC_2: begin
                     state_in = ST_CC_1;
                     emit     = 1'b1;
                     kind_in  = KIND_CONTROL;
                  end
                  ST_PW_1: begin
                     held_first_in = pop_item.data;
                     state_in      = ST_PW_2;
                  end
                  ST_PW_2: begin
                     state_in = ST_PW_1;
                     emit     = 1'b1;
                     kind_in  = KIND_PITCH;
                  end
                  default: state_in = ST_IGNORE;
               endcase
            end
            default: state_in = ST_IGNORE;
         endcase
      end
   end

   assign rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);

   // Parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IGNORE;
         held_first_ff <= '0;
         held_bank_ff  <= BANK_A;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         held_first_ff <= held_first_in;
         held_bank_ff  <= held_bank_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (emit) begin
         kind_ff   <= kind_in;
         first_ff  <= first_in;
         second_ff <= second_in;
         bank_ff   <= held_bank_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_message_kind = kind_ff;
   assign rsp_first_data   = first_ff;
   assign rsp_second_data  = second_ff;
   assign rsp_bank         = bank_ff;

   a_program_second_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && kind_ff == KIND_PROGRAM) |-> (second_ff == '0))
      else $error("program change with nonzero second data");

   a_note_on_velocity: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && kind_ff == KIND_NOTE_ON) |-> (second_ff != '0))
      else $error("note on with zero velocity");

   a_two_bank_kinds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (kind_ff == KIND_PROGRAM || kind_ff == KIND_PITCH))
         |-> (bank_ff != BANK_C))
      else $error("program change or pitch wheel on bank C");

   a_ignore_status: assert property (@(posedge clock) disable iff (reset)
      (pop && pop_item.cmd == CMD_IGNORE) |=> (state_ff == ST_IGNORE))
      else $error("ignored status did not reset parser");

endmodule

// ===== rtl/midi_running_status_parser.sv =====
// Path: an accepted byte is written into the queue, the parser pops it and updates its
// parse state, and a result it completes is registered in the result register.
// Throughput: one byte per cycle while rsp_stall does not hold a pending result.
// Reset (synchronous, active high): channels A/B/C return to 0/1/2, the
// parser goes to the ignore state and the queue and result register empty.
module midi_running_status_parser #(
   parameter int QueueDepth = mrsp_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [7:0] req_midi_byte,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_message_kind,
   output logic [6:0] rsp_first_data,
   output logic [6:0] rsp_second_data,
   output logic [1:0] rsp_bank,
   input  logic       csr_write_en,
   input  logic [1:0] csr_index,
   input  logic [3:0] csr_wdata
);
   import mrsp_pkg::*;

   logic     push, pop, queue_full, pop_valid;
   item_type push_item, pop_item;

   // Classify incoming bytes
   mrsp_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_midi_byte (req_midi_byte),
      .req_stall     (req_stall),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .queue_full    (queue_full),
      .push          (push),
      .push_item     (push_item)
   );

   // Decouple front end from parser
   mrsp_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_item  (pop_item)
   );

   // Parse and deliver results
   mrsp_back u_back (
      .clock            (clock),
      .reset            (reset),
      .pop_valid        (pop_valid),
      .pop_item         (pop_item),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_message_kind (rsp_message_kind),
      .rsp_first_data   (rsp_first_data),
      .rsp_second_data  (rsp_second_data),
      .rsp_bank         (rsp_bank)
   );

endmodule
